>>> hw/rtl/rvu_pkg.sv
package rvu_pkg;

  localparam int VEC_FRAC_BITS   = 14;
  localparam int INDEX_FRAC_BITS = 12;

  localparam int COMP_W = 16;
  localparam int IDX_W  = 16;

  localparam int RATIO_LIMIT = 10000;
  localparam int RATIO_CLAMP = 1000;
  localparam int ZERO_SCALE  = 10000;

  localparam int F = VEC_FRAC_BITS;

  // front end: restoring divider, one quotient bit per stage
  localparam int DIV_STEPS = IDX_W + F;
  localparam int BETA_W    = $clog2(RATIO_LIMIT) + F;
  localparam int LIM_W     = IDX_W + $clog2(RATIO_LIMIT) + 1;

  // back end datapath widths
  localparam int W_W    = COMP_W + BETA_W - F + 1;
  localparam int CRP_W  = W_W + COMP_W;
  localparam int CR_W   = CRP_W + 1;
  localparam int C_W    = F + 3;
  localparam int SQ_W   = 2 * F + 3;
  localparam int UU_W   = 2 * F + 5;
  localparam int WN_W   = CRP_W + 2;
  localparam int VNP_W  = 2 * COMP_W;
  localparam int D_W    = VNP_W + 2;
  localparam int RP_W   = D_W + 1 + COMP_W;
  localparam int X_W    = 2 * F + 1;
  localparam int SQ_STEPS = F + 1;
  localparam int S_W    = F + 1;
  localparam int NUMB_W = WN_W + 1;
  localparam int B_W    = NUMB_W - F;
  localparam int BN_W   = B_W + COMP_W;
  localparam int R_W    = BN_W - F + 1;

  // s1..s4, square root stages, s6, s7
  localparam int BK_STAGES = SQ_STEPS + 7;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int COMP_MAX = 2 ** (COMP_W - 1) - 1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic signed [W_W-1:0]    wv_t;
  typedef logic signed [R_W-1:0]    rv_t;

  typedef struct packed {
    comp_t [2:0]       v;
    comp_t [2:0]       n;
    logic [BETA_W-1:0] beta;
    logic              zero;
  } ray_t;

  function automatic comp_t sat_comp(input rv_t x);
    rv_t hi;
    rv_t lo;
    hi = R_W'(COMP_MAX);
    lo = -hi - R_W'(1);
    if (x > hi) begin
      return COMP_W'(hi);
    end else if (x < lo) begin
      return COMP_W'(lo);
    end
    return COMP_W'(x);
  endfunction

endpackage

>>> hw/rtl/rvu_if.sv
interface rvu_in_if;
  import rvu_pkg::*;

  logic  valid;
  logic  ready;
  comp_t incident_x;
  comp_t incident_y;
  comp_t incident_z;
  comp_t normal_x;
  comp_t normal_y;
  comp_t normal_z;
  idx_t  index_from;
  idx_t  index_to;

  modport source (
    output valid, incident_x, incident_y, incident_z,
    output normal_x, normal_y, normal_z, index_from, index_to,
    input  ready
  );
  modport sink (
    input  valid, incident_x, incident_y, incident_z,
    input  normal_x, normal_y, normal_z, index_from, index_to,
    output ready
  );
endinterface

interface rvu_out_if;
  import rvu_pkg::*;

  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  logic  was_refracted;
  logic  index_zero;

  modport source (
    output valid, out_x, out_y, out_z, was_refracted, index_zero,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, was_refracted, index_zero,
    output ready
  );
endinterface

>>> hw/rtl/rvu_front.sv
module rvu_front (
  input  logic           clk,
  input  logic           rst_n,
  rvu_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output rvu_pkg::ray_t  q_data
);
  import rvu_pkg::*;

  typedef struct packed {
    comp_t [2:0]          v;
    comp_t [2:0]          n;
    idx_t                 dvs;
    logic [DIV_STEPS-1:0] num;
    logic [IDX_W:0]       rem;
    logic [DIV_STEPS-1:0] quo;
    logic                 zero;
    logic                 huge;
  } div_st_t;

  div_st_t fr_r   [DIV_STEPS+1];
  div_st_t fr_nxt [DIV_STEPS+1];
  logic    vf_r   [DIV_STEPS+1];
  logic [IDX_W:0] rsh [DIV_STEPS];
  logic    en;

  // hold the whole divider while the queue cannot take its last stage
  assign en          = !(vf_r[DIV_STEPS] && q_full);
  assign in_ch.ready = en;
  assign q_push      = en && vf_r[DIV_STEPS];

  always_comb begin
    fr_nxt[0].v    = {in_ch.incident_z, in_ch.incident_y, in_ch.incident_x};
    fr_nxt[0].n    = {in_ch.normal_z, in_ch.normal_y, in_ch.normal_x};
    fr_nxt[0].dvs  = in_ch.index_to;
    fr_nxt[0].num  = {in_ch.index_from, F'(0)};
    fr_nxt[0].rem  = '0;
    fr_nxt[0].quo  = '0;
    fr_nxt[0].zero =
      (LIM_W'(in_ch.index_from) * LIM_W'(ZERO_SCALE) < (LIM_W'(1) << INDEX_FRAC_BITS)) ||
      (LIM_W'(in_ch.index_to) * LIM_W'(ZERO_SCALE) < (LIM_W'(1) << INDEX_FRAC_BITS));
    fr_nxt[0].huge =
      LIM_W'(in_ch.index_from) > LIM_W'(in_ch.index_to) * LIM_W'(RATIO_LIMIT);
    for (int k = 0; k < DIV_STEPS; k++) begin
      fr_nxt[k+1] = fr_r[k];
      rsh[k] = {fr_r[k].rem[IDX_W-1:0], fr_r[k].num[DIV_STEPS-1-k]};
      if (rsh[k] >= {1'b0, fr_r[k].dvs}) begin
        fr_nxt[k+1].rem = rsh[k] - {1'b0, fr_r[k].dvs};
        fr_nxt[k+1].quo = {fr_r[k].quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        fr_nxt[k+1].rem = rsh[k];
        fr_nxt[k+1].quo = {fr_r[k].quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        fr_r[k] <= fr_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vf_r[k] <= 1'b0;
      end
    end else if (en) begin
      vf_r[0] <= in_ch.valid;
      for (int k = 0; k < DIV_STEPS; k++) begin
        vf_r[k+1] <= vf_r[k];
      end
    end
  end

  always_comb begin
    q_data.v    = fr_r[DIV_STEPS].v;
    q_data.n    = fr_r[DIV_STEPS].n;
    q_data.zero = fr_r[DIV_STEPS].zero;
    if (fr_r[DIV_STEPS].zero) begin
      q_data.beta = BETA_W'(1) << F;
    end else if (fr_r[DIV_STEPS].huge) begin
      q_data.beta = BETA_W'(RATIO_CLAMP) << F;
    end else begin
      q_data.beta = fr_r[DIV_STEPS].quo[BETA_W-1:0];
    end
  end

endmodule

>>> hw/rtl/rvu_fifo.sv
module rvu_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rvu_pkg::ray_t  push_data,
  output logic           full,
  input  logic           pop,
  output rvu_pkg::ray_t  pop_data,
  output logic           empty
);
  import rvu_pkg::*;

  ray_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = cnt_r == CNT_W'(FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= PTR_W'((int'(wr_r) + 1) % FIFO_DEPTH);
      end
      if (do_pop) begin
        rd_r <= PTR_W'((int'(rd_r) + 1) % FIFO_DEPTH);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/rvu_back.sv
module rvu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rvu_pkg::ray_t  q_data,
  input  logic           q_empty,
  output logic           q_pop,
  rvu_out_if.source      out_ch
);
  import rvu_pkg::*;

  typedef struct packed {
    comp_t [2:0]            v;
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic [2:0][VNP_W-1:0]  vnp;
  } st1_t;

  typedef struct packed {
    comp_t [2:0]            v;
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic [5:0][CRP_W-1:0]  crp;
    logic [2:0][CRP_W-1:0]  wnp;
    logic [D_W-1:0]         d;
  } st2_t;

  typedef struct packed {
    comp_t [2:0]            v;
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic [2:0][C_W-1:0]    c;
    logic [WN_W-1:0]        wn;
    logic [D_W-1:0]         d;
  } st3_t;

  typedef struct packed {
    comp_t [2:0]            v;
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic [WN_W-1:0]        wn;
    logic [2:0][SQ_W-1:0]   sq;
    logic [2:0][RP_W-1:0]   rp;
  } st4_t;

  typedef struct packed {
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic [WN_W-1:0]        wn;
    logic                   refl;
    rv_t [2:0]              rr;
    logic [X_W-1:0]         x;
    logic [X_W-1:0]         res;
  } sqs_t;

  typedef struct packed {
    comp_t [2:0]            n;
    logic                   zero;
    wv_t [2:0]              w;
    logic                   refl;
    rv_t [2:0]              rr;
    logic [B_W-1:0]         b;
  } st6_t;

  typedef struct packed {
    logic                   zero;
    wv_t [2:0]              w;
    logic                   refl;
    rv_t [2:0]              rr;
    logic [2:0][BN_W-1:0]   bn;
  } st7_t;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  sqs_t sq_r   [SQ_STEPS+1];
  sqs_t sq_nxt [SQ_STEPS+1];
  st6_t s6_r, s6_nxt;
  st7_t s7_r, s7_nxt;

  logic vld_r [BK_STAGES];
  logic out_vld_r;
  comp_t [2:0] o_r, o_nxt;
  logic refr_r, refr_nxt;
  logic zero_r;

  logic en;
  logic signed [COMP_W+BETA_W:0] wprod [3];
  logic signed [CR_W-1:0] ucr [3];
  logic signed [CR_W-1:0] ulim;
  logic [UU_W-1:0] uu;
  logic [UU_W-1:0] one_uu;
  logic [X_W-1:0] bitc [SQ_STEPS];
  logic [X_W-1:0] trial [SQ_STEPS];
  logic signed [NUMB_W-1:0] sv;
  logic signed [NUMB_W-1:0] numb;
  rv_t rf [3];

  // advance the whole back end only when the output register can take a transaction
  assign en    = !out_vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  // s1: scale the incident vector, start v.n
  always_comb begin
    s1_nxt.v    = q_data.v;
    s1_nxt.n    = q_data.n;
    s1_nxt.zero = q_data.zero;
    for (int i = 0; i < 3; i++) begin
      wprod[i] = (COMP_W + BETA_W + 1)'($signed(q_data.v[i]) * $signed({1'b0, q_data.beta}));
      s1_nxt.w[i]   = W_W'(wprod[i] >>> F);
      s1_nxt.vnp[i] = VNP_W'($signed(q_data.v[i]) * $signed(q_data.n[i]));
    end
  end

  // s2: cross product terms and w.n terms, finish v.n
  always_comb begin
    s2_nxt.v      = s1_r.v;
    s2_nxt.n      = s1_r.n;
    s2_nxt.zero   = s1_r.zero;
    s2_nxt.w      = s1_r.w;
    s2_nxt.crp[0] = CRP_W'($signed(s1_r.w[1]) * $signed(s1_r.n[2]));
    s2_nxt.crp[1] = CRP_W'($signed(s1_r.w[2]) * $signed(s1_r.n[1]));
    s2_nxt.crp[2] = CRP_W'($signed(s1_r.w[2]) * $signed(s1_r.n[0]));
    s2_nxt.crp[3] = CRP_W'($signed(s1_r.w[0]) * $signed(s1_r.n[2]));
    s2_nxt.crp[4] = CRP_W'($signed(s1_r.w[0]) * $signed(s1_r.n[1]));
    s2_nxt.crp[5] = CRP_W'($signed(s1_r.w[1]) * $signed(s1_r.n[0]));
    for (int i = 0; i < 3; i++) begin
      s2_nxt.wnp[i] = CRP_W'($signed(s1_r.w[i]) * $signed(s1_r.n[i]));
    end
    s2_nxt.d = D_W'($signed(s1_r.vnp[0])) + D_W'($signed(s1_r.vnp[1]))
             + D_W'($signed(s1_r.vnp[2]));
  end

  // s3: finish cross product, clamp each component, sum w.n
  always_comb begin
    s3_nxt.v    = s2_r.v;
    s3_nxt.n    = s2_r.n;
    s3_nxt.zero = s2_r.zero;
    s3_nxt.w    = s2_r.w;
    s3_nxt.d    = s2_r.d;
    s3_nxt.wn   = WN_W'($signed(s2_r.wnp[0])) + WN_W'($signed(s2_r.wnp[1]))
                + WN_W'($signed(s2_r.wnp[2]));
    ulim = CR_W'(1) <<< (F + 1);
    for (int i = 0; i < 3; i++) begin
      ucr[i] = (CR_W'($signed(s2_r.crp[2*i])) - CR_W'($signed(s2_r.crp[2*i+1]))) >>> F;
      if (ucr[i] > ulim) begin
        s3_nxt.c[i] = C_W'(ulim);
      end else if (ucr[i] < -ulim) begin
        s3_nxt.c[i] = C_W'(-ulim);
      end else begin
        s3_nxt.c[i] = C_W'(ucr[i]);
      end
    end
  end

  // s4: squares and the mirror terms
  always_comb begin
    s4_nxt.v    = s3_r.v;
    s4_nxt.n    = s3_r.n;
    s4_nxt.zero = s3_r.zero;
    s4_nxt.w    = s3_r.w;
    s4_nxt.wn   = s3_r.wn;
    for (int i = 0; i < 3; i++) begin
      s4_nxt.sq[i] = SQ_W'($signed(s3_r.c[i]) * $signed(s3_r.c[i]));
      s4_nxt.rp[i] = RP_W'($signed({s3_r.d, 1'b0}) * $signed(s3_r.n[i]));
    end
  end

  // s5 and square root, one result bit per stage
  always_comb begin
    one_uu = UU_W'(1) << (2 * F);
    uu = UU_W'(s4_r.sq[0]) + UU_W'(s4_r.sq[1]) + UU_W'(s4_r.sq[2]);
    sq_nxt[0].n    = s4_r.n;
    sq_nxt[0].zero = s4_r.zero;
    sq_nxt[0].w    = s4_r.w;
    sq_nxt[0].wn   = s4_r.wn;
    sq_nxt[0].refl = uu > one_uu;
    sq_nxt[0].x    = X_W'(one_uu - uu);
    sq_nxt[0].res  = '0;
    for (int i = 0; i < 3; i++) begin
      sq_nxt[0].rr[i] = R_W'($signed(s4_r.v[i])) - R_W'($signed(s4_r.rp[i]) >>> (2 * F));
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitc[k]  = X_W'(1) << (2 * F - 2 * k);
      trial[k] = sq_r[k].res + bitc[k];
      sq_nxt[k+1] = sq_r[k];
      if (sq_r[k].x >= trial[k]) begin
        sq_nxt[k+1].x   = sq_r[k].x - trial[k];
        sq_nxt[k+1].res = (sq_r[k].res >> 1) + bitc[k];
      end else begin
        sq_nxt[k+1].res = sq_r[k].res >> 1;
      end
    end
  end

  // s6: b = floor((-s*2^F - w.n) / 2^F)
  always_comb begin
    s6_nxt.n    = sq_r[SQ_STEPS].n;
    s6_nxt.zero = sq_r[SQ_STEPS].zero;
    s6_nxt.w    = sq_r[SQ_STEPS].w;
    s6_nxt.refl = sq_r[SQ_STEPS].refl;
    s6_nxt.rr   = sq_r[SQ_STEPS].rr;
    sv          = NUMB_W'(sq_r[SQ_STEPS].res[S_W-1:0]);
    numb        = -(sv <<< F) - NUMB_W'($signed(sq_r[SQ_STEPS].wn));
    s6_nxt.b    = B_W'(numb >>> F);
  end

  // s7: b * n
  always_comb begin
    s7_nxt.zero = s6_r.zero;
    s7_nxt.w    = s6_r.w;
    s7_nxt.refl = s6_r.refl;
    s7_nxt.rr   = s6_r.rr;
    for (int i = 0; i < 3; i++) begin
      s7_nxt.bn[i] = BN_W'($signed(s6_r.b) * $signed(s6_r.n[i]));
    end
  end

  // pick mirror or refracted direction, saturate
  always_comb begin
    refr_nxt = !s7_r.refl;
    for (int i = 0; i < 3; i++) begin
      rf[i] = R_W'($signed(s7_r.w[i])) + R_W'($signed(s7_r.bn[i]) >>> F);
      if (s7_r.refl) begin
        o_nxt[i] = sat_comp(s7_r.rr[i]);
      end else begin
        o_nxt[i] = sat_comp(rf[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      s6_r   <= s6_nxt;
      s7_r   <= s7_nxt;
      o_r    <= o_nxt;
      refr_r <= refr_nxt;
      zero_r <= s7_r.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BK_STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_empty;
      for (int k = 1; k < BK_STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[BK_STAGES-1];
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_x         = o_r[0];
  assign out_ch.out_y         = o_r[1];
  assign out_ch.out_z         = o_r[2];
  assign out_ch.was_refracted = refr_r;
  assign out_ch.index_zero    = zero_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(vld_r[BK_STAGES-1]))
    else $error("result appeared without a transaction in the last stage");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[0]) && $stable(vld_r[BK_STAGES-1]))
    else $error("back end moved while the output was stalled");

  a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !sq_r[0].refl |-> sq_r[0].x <= X_W'(one_uu))
    else $error("square root operand out of range on refraction");

endmodule

>>> hw/rtl/refraction_vector_unit.sv
// Refraction vector unit: bends a ray direction at a surface, or mirrors it
// past the critical angle.
// in_ch: valid/ready channel carrying incident and normal vectors (signed
// Q2.14) and the two refractive indices (unsigned Q4.12). A transaction is
// taken on any edge where valid and ready are both high.
// out_ch: valid/ready channel with the new direction (saturated Q2.14),
// was_refracted and index_zero; one result per input, in input order.
// Throughput: one transaction per cycle, sustained while out_ch.ready stays high.
// Path to out_ch.valid: the input register is loaded at the accepting edge,
// then a transaction passes through the radix-2 ratio divider, the 4-entry
// queue, the back end (products, cross product, square root stages) and the
// output register.
// A stalled receiver freezes the back end; the front end keeps accepting
// until the queue fills, then drops ready.
// Reset (rst_n low, synchronous) empties every stage and the queue.
module refraction_vector_unit (
  input  logic       clk,
  input  logic       rst_n,
  rvu_in_if.sink     in_ch,
  rvu_out_if.source  out_ch
);
  import rvu_pkg::*;

  ray_t q_wdata;
  ray_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  rvu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  rvu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rvu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> test/refraction_vector_unit_checker.sv
module refraction_vector_unit_checker (
  input  logic clk,
  input  logic rst_n,
  rvu_in_if    in_ch,
  rvu_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   n_refracted,
  output int   n_reflected,
  output int   n_zero
);
  timeunit 1ns;
  timeprecision 1ps;
  import rvu_pkg::*;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               refr;
    logic               zero;
  } bent_ray_t;

  bent_ray_t bent_q[$];

  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x) begin
        r = r + (longint'(1) << b);
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic bent_ray_t bend_ray(longint v[3], longint n[3], longint ri1, longint ri2);
    bent_ray_t e;
    longint beta, lim, uu, d, s, wn, b, c;
    longint w[3], u[3], r[3];
    e.zero = 1'b0;
    if (ri1 * 10000 < (1 << INDEX_FRAC_BITS) || ri2 * 10000 < (1 << INDEX_FRAC_BITS)) begin
      e.zero = 1'b1;
      beta = longint'(1) << F;
    end else if (ri1 > 10000 * ri2) begin
      beta = longint'(1000) << F;
    end else begin
      beta = (ri1 << F) / ri2;
    end
    for (int i = 0; i < 3; i++) begin
      w[i] = floor_sh(v[i] * beta, F);
    end
    u[0] = floor_sh(w[1] * n[2] - w[2] * n[1], F);
    u[1] = floor_sh(w[2] * n[0] - w[0] * n[2], F);
    u[2] = floor_sh(w[0] * n[1] - w[1] * n[0], F);
    lim = longint'(1) << (F + 1);
    uu = 0;
    for (int i = 0; i < 3; i++) begin
      c = u[i];
      if (c > lim) c = lim;
      if (c < -lim) c = -lim;
      uu += c * c;
    end
    if (uu > (longint'(1) << (2 * F))) begin
      d = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
      e.refr = 1'b0;
      for (int i = 0; i < 3; i++) begin
        r[i] = v[i] - floor_sh(2 * d * n[i], 2 * F);
      end
    end else begin
      s = root_floor((longint'(1) << (2 * F)) - uu);
      wn = w[0] * n[0] + w[1] * n[1] + w[2] * n[2];
      b = floor_sh(-(s << F) - wn, F);
      e.refr = 1'b1;
      for (int i = 0; i < 3; i++) begin
        r[i] = w[i] + floor_sh(b * n[i], F);
      end
    end
    e.x = clip16(r[0]);
    e.y = clip16(r[1]);
    e.z = clip16(r[2]);
    return e;
  endfunction

  assign pending = bent_q.size();

  always @(posedge clk) begin
    bent_ray_t exp_r;
    longint v[3], n[3];
    if (!rst_n) begin
      fail_count <= 0;
      n_refracted <= 0;
      n_reflected <= 0;
      n_zero <= 0;
      bent_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        v[0] = in_ch.incident_x; v[1] = in_ch.incident_y; v[2] = in_ch.incident_z;
        n[0] = in_ch.normal_x;   n[1] = in_ch.normal_y;   n[2] = in_ch.normal_z;
        exp_r = bend_ray(v, n, longint'(in_ch.index_from), longint'(in_ch.index_to));
        bent_q.push_back(exp_r);
        if (exp_r.refr) n_refracted <= n_refracted + 1;
        else n_reflected <= n_reflected + 1;
        if (exp_r.zero) n_zero <= n_zero + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (bent_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = bent_q.pop_front();
          if (out_ch.out_x !== exp_r.x || out_ch.out_y !== exp_r.y ||
              out_ch.out_z !== exp_r.z || out_ch.was_refracted !== exp_r.refr ||
              out_ch.index_zero !== exp_r.zero) begin
            $display({"%0t: mismatch expected %0d %0d %0d refr=%0b zero=%0b",
                      " actual %0d %0d %0d refr=%0b zero=%0b"},
                     $time, exp_r.x, exp_r.y, exp_r.z, exp_r.refr, exp_r.zero,
                     out_ch.out_x, out_ch.out_y, out_ch.out_z,
                     out_ch.was_refracted, out_ch.index_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/refraction_vector_unit_tb.sv
module refraction_vector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rvu_pkg::*;

  localparam int LATENCY = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   fail_count, pending, n_refracted, n_reflected, n_zero, leftover;

  rvu_in_if  in_ch ();
  rvu_out_if out_ch ();

  refraction_vector_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  refraction_vector_unit_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .n_refracted(n_refracted),
    .n_reflected(n_reflected), .n_zero(n_zero)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.incident_x = '0; in_ch.incident_y = '0; in_ch.incident_z = '0;
    in_ch.normal_x = '0;   in_ch.normal_y = '0;   in_ch.normal_z = '0;
    in_ch.index_from = '0; in_ch.index_to = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stalls about a quarter of the time, except in calm stretches
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 25);
  end

  function automatic comp_t unit_comp();
    int r;
    r = $urandom_range(99);
    if (r < 10) return comp_t'($urandom);
    if (r < 20) return (r & 1) ? 16'sh4000 : -16'sh4000;
    return comp_t'($signed($urandom_range(32767)) - 16384);
  endfunction

  function automatic idx_t pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 5) return idx_t'($urandom_range(1));
    if (r < 10) return idx_t'($urandom);
    return idx_t'($urandom_range(12000, 4096));
  endfunction

  task automatic send_ray(comp_t ix, comp_t iy, comp_t iz, comp_t nx, comp_t ny, comp_t nz,
                          idx_t i1, idx_t i2);
    while (!calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.incident_x <= ix; in_ch.incident_y <= iy; in_ch.incident_z <= iz;
    in_ch.normal_x <= nx;   in_ch.normal_y <= ny;   in_ch.normal_z <= nz;
    in_ch.index_from <= i1; in_ch.index_to <= i2;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random();
    send_ray(unit_comp(), unit_comp(), unit_comp(), unit_comp(), unit_comp(), unit_comp(),
             pick_index(), pick_index());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // straight through, glass entry, glass exit past critical angle
    send_ray(16'sh0000, 16'sh0000, -16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000,
             16'h1000, 16'h1800);
    send_ray(16'sh2d41, 16'sh0000, -16'sh2d41, 16'sh0000, 16'sh0000, 16'sh4000,
             16'h1000, 16'h1800);
    send_ray(16'sh2d41, 16'sh0000, -16'sh2d41, 16'sh0000, 16'sh0000, 16'sh4000,
             16'h1800, 16'h1000);
    // zero and near-zero indices
    send_ray(16'sh1000, 16'sh2000, -16'sh3000, 16'sh0000, 16'sh4000, 16'sh0000,
             16'h0000, 16'h1000);
    send_ray(16'sh1000, 16'sh2000, -16'sh3000, 16'sh0000, 16'sh4000, 16'sh0000,
             16'h1000, 16'h0000);
    send_ray(16'sh1000, 16'sh2000, -16'sh3000, 16'sh0000, 16'sh4000, 16'sh0000,
             16'h0001, 16'h0001);
    send_ray(16'sh1000, 16'sh2000, -16'sh3000, 16'sh0000, 16'sh4000, 16'sh0000,
             16'h0000, 16'h0000);
    // huge ratio clamp and its boundary
    send_ray(16'sh0000, 16'sh0000, -16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000,
             16'hffff, 16'h0001);
    send_ray(16'sh0001, 16'sh0000, -16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000,
             16'd60000, 16'd6);
    send_ray(16'sh0001, 16'sh0000, -16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000,
             16'd60001, 16'd6);
    // field extremes, saturation
    send_ray(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'hffff, 16'hffff);
    send_ray(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
             16'h1000, 16'hffff);
    send_ray(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
             16'hffff, 16'h1000);
    send_ray(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
             16'h1000, 16'h1000);
    send_ray(16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh0000, 16'sh4000, 16'sh0000,
             16'haaaa, 16'h5555);
    for (int k = 0; k < 900; k++) send_random();
    // hold until the pipeline is empty
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    calm <= 1'b1;
    for (int k = 0; k < 300; k++) send_random();
    calm <= 1'b0;
    for (int k = 0; k < 700; k++) send_random();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    leftover = pending;
    $display("Sent %0d rays: %0d refracted, %0d totally reflected, %0d with a zero index.",
             n_refracted + n_reflected, n_refracted, n_reflected, n_zero);
    if (fail_count == 0 && leftover == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
